[design/dvpd_pkg.sv]
// Shared types and constants of the delta varint posting decoder.
package dvpd_pkg;

  // Width of a document id and of the id counter
  localparam int unsigned ID_WIDTH    = 64;
  localparam int unsigned COUNT_WIDTH = 32;
  // Configuration register width
  localparam int unsigned CFG_WIDTH   = 32;
  // LEB128 group size and width of the group shift position
  localparam int unsigned GROUP_BITS  = 7;
  localparam int unsigned SHIFT_W     = 7;
  // Largest group position ever held: last legal position plus one group
  localparam int unsigned SHIFT_MAX   = ((ID_WIDTH + GROUP_BITS - 1) / GROUP_BITS) * GROUP_BITS;

  typedef logic [ID_WIDTH-1:0]    id_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SHIFT_W-1:0]     shift_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_TRAILING  = 3'd4
  } status_e;

endpackage

[design/dvpd_if.sv]
// Valid/ready channel interfaces for encoded bytes and decoded results.
interface dvpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dvpd_result_if;
  logic             valid;
  logic             ready;
  dvpd_pkg::id_t     doc_id;
  logic             has_doc_id;
  dvpd_pkg::status_e status;
  logic             end_of_list;

  modport source (output valid, output doc_id, output has_doc_id, output status,
                  output end_of_list, input ready);
  modport sink   (input valid, input doc_id, input has_doc_id, input status,
                  input end_of_list, output ready);
endinterface

[design/delta_varint_posting_decoder_unit.sv]
// A transferred byte is held in the byte register; its result is then registered in the result register.
// Throughput: one byte per cycle unless the result side stalls; the per-byte shift-or
// and the 64-bit add share one stage between the byte register and the result register.
// Stalls from the result side propagate back through the two register stages.
// Reset (async, active low) clears list state, the count register and both valid flags.
// Every byte flagged last clears the list state for the next list.
module delta_varint_posting_decoder_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [dvpd_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  dvpd_byte_if.sink              in_i,
  dvpd_result_if.source          out_o
);
  import dvpd_pkg::*;

  // Configuration
  count_t  expected_count_q;

  // Byte register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // List state
  id_t     partial_q, partial_d;
  shift_t  shift_q, shift_d;
  id_t     running_q, running_d;
  count_t  count_q, count_d;
  logic    error_q, error_d;

  // Result register
  logic    res_valid_q;
  id_t     res_id_q;
  logic    res_has_q;
  status_e res_status_q;
  logic    res_eol_q;

  // Per-byte results
  id_t            merged;
  logic [ID_WIDTH:0] sum;
  id_t            next_id;
  logic           first;
  status_e        status;
  logic           has_id;
  logic           emit;
  logic           advance;

  // Stage control
  assign advance     = !res_valid_q || out_o.ready;
  assign in_i.ready  = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_count_q <= '0;
    end else if (cfg_we_i) begin
      expected_count_q <= cfg_wdata_i[COUNT_WIDTH-1:0];
    end
  end

  // Byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Group merge and delta add
  assign merged = partial_q | (ID_WIDTH'(in_byte_q[GROUP_BITS-1:0]) << shift_q);
  assign sum    = {1'b0, running_q} + {1'b0, merged};
  assign first  = (count_q == '0);

  // Decode step: next list state and result
  always_comb begin
    partial_d = partial_q;
    shift_d   = shift_q;
    running_d = running_q;
    count_d   = count_q;
    error_d   = error_q;
    status    = ST_OK;
    has_id    = 1'b0;
    emit      = 1'b0;
    next_id   = first ? merged : sum[ID_WIDTH-1:0];

    if (!error_q) begin
      priority if (count_q >= expected_count_q) begin
        status = ST_TRAILING;
      end else if (shift_q >= SHIFT_W'(ID_WIDTH)) begin
        status = ST_TOO_LONG;
      end else begin
        partial_d = merged;
        if (!in_byte_q[7]) begin
          // final byte of a varint
          if (!first && sum[ID_WIDTH]) begin
            status = ST_OVERFLOW;
          end else begin
            // a zero delta repeats the previous id: counted, not shown
            if (first || merged != '0) begin
              has_id = 1'b1;
              emit   = 1'b1;
            end
            running_d = next_id;
            count_d   = count_q + 1'b1;
            partial_d = '0;
            shift_d   = '0;
          end
        end else begin
          shift_d = shift_q + SHIFT_W'(GROUP_BITS);
        end
      end

      if (status != ST_OK) begin
        error_d = 1'b1;
        emit    = 1'b1;
      end else if (in_last_q && (shift_d != '0 || partial_d != '0 ||
                                 count_d < expected_count_q)) begin
        status = ST_TRUNCATED;
      end
    end

    // end of list: always a result, then clear
    if (in_last_q) begin
      emit      = 1'b1;
      partial_d = '0;
      shift_d   = '0;
      running_d = '0;
      count_d   = '0;
      error_d   = 1'b0;
    end
  end

  // List state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      shift_q   <= '0;
      running_q <= '0;
      count_q   <= '0;
      error_q   <= 1'b0;
    end else if (advance && in_valid_q) begin
      partial_q <= partial_d;
      shift_q   <= shift_d;
      running_q <= running_d;
      count_q   <= count_d;
      error_q   <= error_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      res_id_q     <= has_id ? next_id : '0;
      res_has_q    <= has_id;
      res_status_q <= status;
      res_eol_q    <= in_last_q;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.doc_id      = res_id_q;
  assign out_o.has_doc_id  = res_has_q;
  assign out_o.status      = res_status_q;
  assign out_o.end_of_list = res_eol_q;

`ifndef SYNTHESIS
  // An id only travels with a clean or truncated status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.has_doc_id |->
      out_o.status == ST_OK || out_o.status == ST_TRUNCATED)
    else $error("id reported together with an error status");

  // A result without an id carries a zero id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.has_doc_id |-> out_o.doc_id == '0)
    else $error("nonzero id on a result without id");

  // Group position never runs past one group beyond the id width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q <= SHIFT_W'(SHIFT_MAX))
    else $error("group position out of range");

  // A stalled result with a byte waiting blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready && in_valid_q |-> !in_i.ready)
    else $error("input accepted while both stages are full");

  // The last byte of a list leaves the list state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && in_last_q |=> count_q == '0 && !error_q && shift_q == '0)
    else $error("list state not cleared after last byte");
`endif

endmodule
